FILE: rtl/vlcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlcp_pkg
// Shared constants, codes and types of the variable-length code packer.
// ----------------------------------------------------------------------------
package vlcp_pkg;

    localparam int WORD_BITS         = 32;
    localparam int SYM_W             = 8;
    localparam int LEN_W             = 6;
    localparam int NUM_SYMBOLS_DEF   = 256;
    localparam int MAX_CODE_BITS_DEF = 32;

    // Result queue: deep enough for two results of the item in the packing
    // stage, two of the next one and a few waiting at the output.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = FIFO_PTR_W + 1;

    // Item kinds carried on the input tuser bit.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 eos;
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] code;
    } t_lookup;

    typedef struct packed {
        logic                 length_error;
        logic [WORD_BITS-1:0] total_bits;
        logic [LEN_W-1:0]     valid_bits;
        logic [WORD_BITS-1:0] packed_word;
        logic                 is_last;
    } t_result;

    typedef struct packed {
        logic    first_vld;
        logic    second_vld;
        t_result first;
        t_result second;
    } t_push;

endpackage
`default_nettype wire

FILE: rtl/vlcp_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlcp_table
// Code value and code length memories with a registered read port.
// ----------------------------------------------------------------------------
module vlcp_table #(
    parameter int NUM_SYMBOLS   = vlcp_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = vlcp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_wr_en,
    input  wire                             i_rd_en,
    input  wire  [vlcp_pkg::SYM_W-1:0]      i_sym,
    input  wire  [vlcp_pkg::WORD_BITS-1:0]  i_value,
    input  wire  [vlcp_pkg::LEN_W-1:0]      i_len,
    input  wire                             i_eos,
    output vlcp_pkg::t_lookup               o_lookup
);

    localparam int IDX_W = $clog2(NUM_SYMBOLS);

    logic [vlcp_pkg::WORD_BITS-1:0] r_code_mem [NUM_SYMBOLS];
    logic [vlcp_pkg::LEN_W-1:0]     r_len_mem  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]         r_len_vld;

    logic [vlcp_pkg::WORD_BITS-1:0] r_rd_code;
    logic [vlcp_pkg::LEN_W-1:0]     r_rd_len;
    logic                           r_rd_hit;
    logic                           r_p_valid;
    logic                           r_p_eos;

    logic                           sym_ok;
    logic [IDX_W-1:0]               idx;
    logic [vlcp_pkg::LEN_W-1:0]     len_sat;
    logic [vlcp_pkg::WORD_BITS-1:0] mask;

    assign sym_ok  = {1'b0, i_sym} < (vlcp_pkg::SYM_W+1)'(NUM_SYMBOLS);
    assign idx     = i_sym[IDX_W-1:0];
    assign len_sat = (i_len > vlcp_pkg::LEN_W'(MAX_CODE_BITS))
                   ? vlcp_pkg::LEN_W'(MAX_CODE_BITS) : i_len;
    assign mask    = (len_sat >= vlcp_pkg::LEN_W'(vlcp_pkg::WORD_BITS)) ? '1
                   : ((vlcp_pkg::WORD_BITS'(1) << len_sat) - vlcp_pkg::WORD_BITS'(1));

    // Store code bits pre-masked so the packer never sees bits above the length.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && sym_ok) begin
            r_code_mem[idx] <= i_value & mask;
            r_len_mem[idx]  <= len_sat;
        end
        r_rd_code <= r_code_mem[idx];
        r_rd_len  <= r_len_mem[idx];
        r_rd_hit  <= sym_ok && r_len_vld[idx];
        r_p_eos   <= i_eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_wr_en && sym_ok) begin
                r_len_vld[idx] <= 1'b1;
            end
            r_p_valid <= i_rd_en;
        end
    end

    always_comb begin
        o_lookup       = '0;
        o_lookup.valid = r_p_valid;
        o_lookup.eos   = r_p_eos;
        o_lookup.len   = r_rd_hit ? r_rd_len : '0;
        o_lookup.code  = r_rd_code;
    end

endmodule
`default_nettype wire

FILE: rtl/vlcp_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlcp_pack
// Bit accumulator: appends codes LSB first, emits full and flushed words.
// ----------------------------------------------------------------------------
module vlcp_pack (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  vlcp_pkg::t_lookup  i_lookup,
    output vlcp_pkg::t_push    o_push
);

    localparam int WB = vlcp_pkg::WORD_BITS;
    localparam int LW = vlcp_pkg::LEN_W;

    logic [WB-1:0]   r_acc,   n_acc;
    logic [LW-2:0]   r_fill,  n_fill;
    logic [WB-1:0]   r_total, n_total;
    logic            r_err,   n_err;

    logic            len_zero;
    logic [2*WB-1:0] acc_wide;
    logic [LW-1:0]   fill_sum;
    logic [WB:0]     tot_sum;
    logic            full;
    logic [WB-1:0]   upd_acc;
    logic [LW-2:0]   upd_fill;
    logic [WB-1:0]   upd_total;
    logic            upd_err;
    logic            flush;

    always_comb begin
        len_zero  = (i_lookup.len == '0);
        acc_wide  = {{WB{1'b0}}, r_acc} | ((2*WB)'(i_lookup.code) << r_fill);
        fill_sum  = {1'b0, r_fill} + i_lookup.len;
        tot_sum   = {1'b0, r_total} + (WB+1)'(i_lookup.len);
        full      = !len_zero && fill_sum[LW-1];
        if (len_zero) begin
            upd_acc   = r_acc;
            upd_fill  = r_fill;
            upd_total = r_total;
        end else begin
            upd_acc   = fill_sum[LW-1] ? acc_wide[2*WB-1:WB] : acc_wide[WB-1:0];
            upd_fill  = fill_sum[LW-2:0];
            upd_total = tot_sum[WB] ? '1 : tot_sum[WB-1:0];
        end
        upd_err = r_err || len_zero;
        flush   = i_lookup.eos && ((upd_fill != '0) || !full);

        o_push                     = '0;
        o_push.second.packed_word  = upd_acc;
        o_push.second.valid_bits   = {1'b0, upd_fill};
        o_push.second.total_bits   = upd_total;
        o_push.second.is_last      = 1'b1;
        o_push.second.length_error = upd_err;
        if (full) begin
            o_push.first.packed_word  = acc_wide[WB-1:0];
            o_push.first.valid_bits   = LW'(WB);
            o_push.first.total_bits   = upd_total;
            o_push.first.is_last      = i_lookup.eos && (upd_fill == '0);
            o_push.first.length_error = upd_err;
        end else begin
            o_push.first = o_push.second;
        end
        o_push.first_vld  = i_lookup.valid && (full || flush);
        o_push.second_vld = i_lookup.valid && full && flush;

        n_acc   = r_acc;
        n_fill  = r_fill;
        n_total = r_total;
        n_err   = r_err;
        if (i_lookup.valid) begin
            if (i_lookup.eos) begin
                n_acc   = '0;
                n_fill  = '0;
                n_total = '0;
                n_err   = 1'b0;
            end else begin
                n_acc   = upd_acc;
                n_fill  = upd_fill;
                n_total = upd_total;
                n_err   = upd_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_err   <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vlcp_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlcp_out_fifo
// Result queue taking up to two entries per cycle and giving one.
// ----------------------------------------------------------------------------
module vlcp_out_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  vlcp_pkg::t_push                    i_push,
    output logic                               o_valid,
    input  wire                                i_ready,
    output vlcp_pkg::t_result                  o_data,
    output logic [vlcp_pkg::FIFO_LVL_W-1:0]    o_level
);

    localparam int PW = vlcp_pkg::FIFO_PTR_W;
    localparam int LV = vlcp_pkg::FIFO_LVL_W;

    vlcp_pkg::t_result r_mem [vlcp_pkg::FIFO_DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [LV-1:0]     r_level,  n_level;
    logic              pop;
    logic [LV-1:0]     push_n;

    assign pop     = (r_level != '0) && i_ready;
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    always_comb begin
        push_n   = LV'(i_push.first_vld) + LV'(i_push.second_vld);
        n_wr_ptr = r_wr_ptr + PW'(push_n);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_level  = r_level + push_n - LV'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.second_vld) begin
            r_mem[r_wr_ptr + PW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/variable_length_code_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// variable_length_code_packer
// Table-driven LSB-first bit packer for byte symbols.
//
// Input channel s_axis: tuser selects a table write (store code value and
// length of entry symbol) or an encode (append the code of symbol). tlast on
// an encode ends the stream: the partial word is flushed after the symbol.
// Output channel m_axis: each transaction carries one 32-bit word, its count
// of valid bits, the running stream bit total and the sticky length error;
// tlast marks the final word of a stream.
// A result reaches m_axis through the table read register, loaded when its
// input transaction is accepted, and then the result queue.
// Throughput: one input transaction per cycle while the receiver keeps up;
// the single-port table read plus one shift-or pack sets that figure. An
// item may produce up to two results; the 8-entry result queue absorbs this.
// Reset clears all code lengths (valid bits per entry), the accumulator, the
// fill count, the total and the error flag; code values stay undefined.
// When m_axis stalls, the queue fills and s_axis_tready drops once fewer
// than two free entries remain beyond what the packing stage may push.
// ----------------------------------------------------------------------------
module variable_length_code_packer #(
    parameter int NUM_SYMBOLS   = vlcp_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_BITS = vlcp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // symbol[7:0], code_value[39:8],
                                        // code_length[45:40], zero pad[47:46]
    input  wire  [0:0]  s_axis_tuser,   // func[0]
    input  wire         s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // packed_word[31:0], valid_bits[37:32],
                                        // total_bits[69:38], length_error[70],
                                        // zero pad[71]
    output logic        m_axis_tlast    // is_last
);

    localparam int LV = vlcp_pkg::FIFO_LVL_W;

    logic                            accept;
    logic                            is_encode;
    logic [vlcp_pkg::SYM_W-1:0]      in_symbol;
    logic [vlcp_pkg::WORD_BITS-1:0]  in_code_value;
    logic [vlcp_pkg::LEN_W-1:0]      in_code_length;

    vlcp_pkg::t_lookup               lookup;
    vlcp_pkg::t_push                 push;
    vlcp_pkg::t_result               head;
    logic [LV-1:0]                   level;
    logic [LV:0]                     reserve;

    // Unpack the input transaction.
    assign in_symbol      = s_axis_tdata[7:0];
    assign in_code_value  = s_axis_tdata[39:8];
    assign in_code_length = s_axis_tdata[45:40];
    assign is_encode      = (s_axis_tuser[0] == vlcp_pkg::FUNC_ENCODE);
    assign accept         = s_axis_tvalid && s_axis_tready;

    // Hold off input during reset and unless the queue can take two results
    // from the packing stage and two more from the item accepted now; pops
    // are not counted.
    assign reserve       = {1'b0, level} + (LV+1)'(lookup.valid ? 2 : 0) + (LV+1)'(2);
    assign s_axis_tready = i_rst_n && (reserve <= (LV+1)'(vlcp_pkg::FIFO_DEPTH));

    vlcp_table #(
        .NUM_SYMBOLS   (NUM_SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (accept && !is_encode),
        .i_rd_en  (accept && is_encode),
        .i_sym    (in_symbol),
        .i_value  (in_code_value),
        .i_len    (in_code_length),
        .i_eos    (s_axis_tlast),
        .o_lookup (lookup)
    );

    vlcp_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup),
        .o_push   (push)
    );

    vlcp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head),
        .o_level (level)
    );

    // Pack the queue head into the output transaction.
    assign m_axis_tdata = {1'b0, head.length_error, head.total_bits,
                           head.valid_bits, head.packed_word};
    assign m_axis_tlast = head.is_last;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the variable-length code packer.
//
// Stream items go in on s_axis: table writes and symbol encodes. A scoreboard
// class keeps its own code table, bit accumulator, fill count, stream total
// and error flag. For each accepted item it works out the words the packer
// must emit. Each word taken from m_axis is checked field by field against
// the oldest word still due.
//
// The run starts with a short directed part: masking, length saturation,
// zero-length symbols, exact word fills, flushes with an empty accumulator
// and end of stream on a table write. Random phases follow, each with its own
// mix of sender gaps and receiver stalls. The last phase holds the receiver
// off long enough for the packer to fill up and stall its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int SETTLE_TAIL  = 20;
    localparam int LIVE_SLOTS   = 16;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the packer state and the words still due
    // ------------------------------------------------------------------------
    class bitstream_scoreboard;
        logic [vlcp_pkg::LEN_W-1:0]     len_tab  [vlcp_pkg::NUM_SYMBOLS_DEF];
        logic [vlcp_pkg::WORD_BITS-1:0] code_tab [vlcp_pkg::NUM_SYMBOLS_DEF];
        logic [vlcp_pkg::WORD_BITS-1:0] acc;
        logic [4:0]                     fill;
        logic [vlcp_pkg::WORD_BITS-1:0] total;
        logic                           err_seen;
        vlcp_pkg::t_result              words_due [$];
        int                             errors;

        function new();
            for (int i = 0; i < vlcp_pkg::NUM_SYMBOLS_DEF; i++) begin
                len_tab[i] = '0;
            end
            acc      = '0;
            fill     = '0;
            total    = '0;
            err_seen = 1'b0;
            errors   = 0;
        endfunction

        function logic [vlcp_pkg::WORD_BITS-1:0] low_mask(logic [vlcp_pkg::LEN_W-1:0] n);
            logic [63:0] m;
            m = (64'd1 << n) - 64'd1;
            return m[vlcp_pkg::WORD_BITS-1:0];
        endfunction

        function void queue_word(logic [vlcp_pkg::WORD_BITS-1:0] word,
                                 logic [vlcp_pkg::LEN_W-1:0] vbits, logic last);
            vlcp_pkg::t_result r;
            r.packed_word  = word;
            r.valid_bits   = vbits;
            r.total_bits   = total;
            r.is_last      = last;
            r.length_error = err_seen;
            words_due.push_back(r);
        endfunction

        // Advance the mirror by one accepted item and queue the words it causes.
        function void note_item(logic func, logic [vlcp_pkg::SYM_W-1:0] sym,
                                logic [vlcp_pkg::WORD_BITS-1:0] value,
                                logic [vlcp_pkg::LEN_W-1:0] len, logic eos);
            logic [vlcp_pkg::LEN_W-1:0]     l;
            logic [63:0]                    code;
            logic [63:0]                    acc64;
            logic [6:0]                     nfill;
            logic [vlcp_pkg::WORD_BITS:0]   sum;
            logic                           full;
            logic [vlcp_pkg::WORD_BITS-1:0] full_word;
            if (func == vlcp_pkg::FUNC_WRITE) begin
                // Saturate the length and drop code bits above it.
                l = (len > vlcp_pkg::MAX_CODE_BITS_DEF)
                  ? vlcp_pkg::LEN_W'(vlcp_pkg::MAX_CODE_BITS_DEF) : len;
                len_tab[sym]  = l;
                code_tab[sym] = value & low_mask(l);
                return;
            end
            l         = len_tab[sym];
            full      = 1'b0;
            full_word = '0;
            if (l == 0) begin
                err_seen = 1'b1;
            end else begin
                code  = {32'd0, code_tab[sym] & low_mask(l)};
                acc64 = {32'd0, acc} | (code << fill);
                nfill = {2'b00, fill} + {1'b0, l};
                sum   = {1'b0, total} + {27'd0, l};
                total = sum[vlcp_pkg::WORD_BITS] ? '1 : sum[vlcp_pkg::WORD_BITS-1:0];
                if (nfill >= vlcp_pkg::WORD_BITS) begin
                    full      = 1'b1;
                    full_word = acc64[vlcp_pkg::WORD_BITS-1:0];
                    acc64     = acc64 >> vlcp_pkg::WORD_BITS;
                    nfill     = nfill - 7'(vlcp_pkg::WORD_BITS);
                end
                acc  = acc64[vlcp_pkg::WORD_BITS-1:0];
                fill = nfill[4:0];
            end
            if (full) begin
                queue_word(full_word, vlcp_pkg::LEN_W'(vlcp_pkg::WORD_BITS),
                           eos && (fill == 0));
            end
            if (eos) begin
                if (fill != 0 || !full) begin
                    queue_word((fill != 0) ? (acc & low_mask({1'b0, fill})) : '0,
                               {1'b0, fill}, 1'b1);
                end
                acc      = '0;
                fill     = '0;
                total    = '0;
                err_seen = 1'b0;
            end
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one output transaction with the oldest word due.
        task check_word(input logic [71:0] data, input logic last);
            vlcp_pkg::t_result want;
            if (words_due.size() == 0) begin
                report_mismatch($sformatf("word %h arrived with nothing due", data[31:0]));
                return;
            end
            want = words_due.pop_front();
            if (data[31:0] !== want.packed_word)
                report_mismatch($sformatf("packed_word %h, want %h",
                                          data[31:0], want.packed_word));
            if (data[37:32] !== want.valid_bits)
                report_mismatch($sformatf("valid_bits %0d, want %0d",
                                          data[37:32], want.valid_bits));
            if (data[69:38] !== want.total_bits)
                report_mismatch($sformatf("total_bits %0d, want %0d",
                                          data[69:38], want.total_bits));
            if (data[70] !== want.length_error)
                report_mismatch($sformatf("length_error %b, want %b",
                                          data[70], want.length_error));
            if (last !== want.is_last)
                report_mismatch($sformatf("is_last %b, want %b", last, want.is_last));
        endtask

        function int outstanding();
            return words_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // symbol[7:0], code_value[39:8], code_length[45:40], pad
    logic [0:0]  s_axis_tuser;   // func[0]
    logic        s_axis_tlast;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // packed_word[31:0], valid_bits[37:32],
                                 // total_bits[69:38], length_error[70], pad
    logic        m_axis_tlast;   // is_last

    bitstream_scoreboard sb = new();

    int          idle_pct;       // sender gap chance, percent per item
    int          stall_pct;      // receiver stall chance, percent per cycle
    logic        hold_req;       // ask the receiver for one long hold-off
    logic        hold_done;
    logic [7:0]  live_syms [LIVE_SLOTS];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    variable_length_code_packer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here in cycles
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check every output transaction; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Offer one item, with a random gap first; hold it until the transaction.
    task put_item(input logic func, input logic [7:0] sym, input logic [31:0] value,
                  input logic [5:0] len, input logic eos);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, len, value, sym};
        s_axis_tuser  <= func;
        s_axis_tlast  <= eos;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_item(func, sym, value, len, eos);
    endtask

    // One random item: mostly encodes of live symbols, some table writes.
    task random_item();
        logic [7:0]  sym;
        logic [5:0]  len;
        int          pick;
        if ($urandom_range(99) < 10) begin
            sym  = 8'($urandom_range(255));
            pick = $urandom_range(9);
            if (pick == 0)
                len = 6'd0;
            else if (pick == 1)
                len = 6'($urandom_range(63, 33));
            else
                len = 6'($urandom_range(32, 1));
            put_item(vlcp_pkg::FUNC_WRITE, sym, $urandom, len, 1'($urandom_range(1)));
            if (len != 0) begin
                live_syms[$urandom_range(LIVE_SLOTS-1)] = sym;
            end
        end else begin
            if ($urandom_range(99) < 90)
                sym = live_syms[$urandom_range(LIVE_SLOTS-1)];
            else
                sym = 8'($urandom_range(255));
            // Value and length are don't-care on an encode; toggle them anyway.
            put_item(vlcp_pkg::FUNC_ENCODE, sym, $urandom, 6'($urandom_range(63)),
                     ($urandom_range(99) < 8));
        end
    endtask

    task random_phase(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct <= stall;
        repeat (count) random_item();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = vlcp_pkg::FUNC_WRITE;
        s_axis_tlast  = 1'b0;
        hold_req      = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero-length symbol right after reset, flushed on an empty
        // accumulator.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd5, 32'd0, 6'd0, 1'b1);
        // Table writes: full width, masking above the length, saturated length,
        // unused entry, and end of stream on a write (ignore it).
        put_item(vlcp_pkg::FUNC_WRITE, 8'd0,   32'hFFFF_FFFF, 6'd32, 1'b0);
        put_item(vlcp_pkg::FUNC_WRITE, 8'd255, 32'hFFFF_FFFF, 6'd1,  1'b0);
        put_item(vlcp_pkg::FUNC_WRITE, 8'd1,   32'hA5A5_A5A5, 6'd63, 1'b0);
        put_item(vlcp_pkg::FUNC_WRITE, 8'd2,   32'h1234_5678, 6'd0,  1'b0);
        put_item(vlcp_pkg::FUNC_WRITE, 8'd3,   32'hFFFF_FFFD, 6'd3,  1'b1);
        // Exact word fill, then a fill with carry, a zero-length symbol and a flush.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd0,   32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd255, 32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd1,   32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd2,   32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd3,   32'd0, 6'd0, 1'b1);
        // Word filled exactly at end of stream: single word marked last.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd0,   32'd0, 6'd0, 1'b1);
        // Partial flush only.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd3,   32'd0, 6'd0, 1'b1);
        // Empty flush carrying the error flag.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd2,   32'd0, 6'd0, 1'b1);
        // Full word plus partial word from one item.
        put_item(vlcp_pkg::FUNC_WRITE,  8'd255, 32'h8765_4321, 6'd32, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd3,   32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd255, 32'd0, 6'd0, 1'b1);
        // Unwritten symbol mid-stream.
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd3,   32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd200, 32'd0, 6'd0, 1'b0);
        put_item(vlcp_pkg::FUNC_ENCODE, 8'd3,   32'd0, 6'd0, 1'b1);

        // Seed a set of live symbols with random codes.
        for (int i = 0; i < LIVE_SLOTS; i++) begin
            live_syms[i] = 8'($urandom_range(255));
            put_item(vlcp_pkg::FUNC_WRITE, live_syms[i], $urandom,
                     6'($urandom_range(32, 1)), 1'($urandom_range(1)));
        end

        random_phase(250, 0, 0);
        random_phase(250, 78, 0);
        random_phase(250, 0, 78);
        random_phase(250, 8, 8);
        // Pressure: long receiver hold-off while the sender keeps offering.
        hold_req <= 1'b1;
        random_phase(100, 0, 30);

        s_axis_tvalid <= 1'b0;
        stall_pct     <= 0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            sb.report_mismatch($sformatf("%0d words never arrived", sb.outstanding()));
        end
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/vlcp_pkg.sv
rtl/vlcp_table.sv
rtl/vlcp_pack.sv
rtl/vlcp_out_fifo.sv
rtl/variable_length_code_packer.sv
dv/testbench.sv
